/* rtl/fmhp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmhp_pkg: shared types and constants of the FLAC metadata header parser
// Result kinds, register indexes, parse phases and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fmhp_pkg;

   localparam int SI_BYTES   = 18;
   localparam int SI_IDX_W   = 5;
   localparam int DIVIDEND_W = 42;
   localparam int DIVISOR_W  = 20;
   localparam int DIV_CNT_W  = 6;
   localparam int RSP_DATA_W = 224;

   localparam logic [15:0] MAX_BLOCK_RESET = 16'd4608;
   localparam logic [15:0] SEEK_CAP_RESET  = 16'd5000;
   localparam logic [9:0]  MS_PER_SEC      = 10'd1000;
   localparam logic [31:0] ALL_ONES_32     = 32'hffffffff;

   localparam logic [2:0] KIND_SUMMARY   = 3'd0;
   localparam logic [2:0] KIND_SEEK      = 3'd1;
   localparam logic [2:0] KIND_NO_SIG    = 3'd2;
   localparam logic [2:0] KIND_TOO_LARGE = 3'd3;
   localparam logic [2:0] KIND_NO_SINFO  = 3'd4;
   localparam logic [2:0] KIND_TRUNC     = 3'd5;

   localparam logic CSR_MAX_BLOCK = 1'b0;
   localparam logic CSR_SEEK_CAP  = 1'b1;

   localparam logic [6:0] BT_STREAMINFO = 7'd0;
   localparam logic [6:0] BT_SEEKTABLE  = 7'd3;

   typedef enum logic [6:0] {
      PH_SIG  = 7'b0000001,
      PH_ID3  = 7'b0000010,
      PH_SKIP = 7'b0000100,
      PH_SIG2 = 7'b0001000,
      PH_HEAD = 7'b0010000,
      PH_BODY = 7'b0100000,
      PH_DONE = 7'b1000000
   } phase_type;

   typedef enum logic [4:0] {
      S_IN  = 5'b00001,
      S_MUL = 5'b00010,
      S_DST = 5'b00100,
      S_DIV = 5'b01000,
      S_OUT = 5'b10000
   } state_type;

   typedef struct packed {
      logic                clear;
      logic                si_clr;
      logic                si_wr;
      logic [SI_IDX_W-1:0] si_idx;
      logic                seek_shift;
      logic                seek_done;
      logic                mt_set;
      logic                mt_add;
      logic [31:0]         mt_val;
      logic                mul_load;
      logic                div_start;
      logic [2:0]          out_kind;
   } cmd_type;

   typedef struct packed {
      logic maxb_over;
      logic seek_ok;
      logic div_busy;
   } status_type;

   function automatic logic [7:0] flac_sig_byte(input logic [1:0] i);
      logic [7:0] r;
      unique case (i)
         2'd0: r = 8'h66;
         2'd1: r = 8'h4c;
         2'd2: r = 8'h61;
         default: r = 8'h43;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] id3_sig_byte(input logic [1:0] i);
      logic [7:0] r;
      unique case (i)
         2'd0: r = 8'h49;
         2'd1: r = 8'h44;
         default: r = 8'h33;
      endcase
      return r;
   endfunction

endpackage

/* rtl/fmhp_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmhp_div: iterative restoring divider
// Produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fmhp_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [fmhp_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [fmhp_pkg::DIVISOR_W-1:0]   divisor,
   output logic                             busy,
   output logic [fmhp_pkg::DIVIDEND_W-1:0]  quotient
);
   logic [fmhp_pkg::DIVIDEND_W-1:0] q_ff, q_in;
   logic [fmhp_pkg::DIVISOR_W:0]    rem_ff, rem_in;
   logic [fmhp_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic [fmhp_pkg::DIVISOR_W:0]    trial;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[fmhp_pkg::DIVISOR_W-1:0], q_ff[fmhp_pkg::DIVIDEND_W-1]};
      if (start) begin
         q_in    = dividend;
         rem_in  = '0;
         cnt_in  = fmhp_pkg::DIV_CNT_W'(fmhp_pkg::DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
            q_in   = {q_ff[fmhp_pkg::DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[fmhp_pkg::DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == fmhp_pkg::DIV_CNT_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

   assign busy     = busy_ff;
   assign quotient = q_ff;
endmodule

/* rtl/fmhp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmhp_ctrl: parse controller
// Walks signature, tag and block headers, counts block bytes and sequences
// the result words.
// ----------------------------------------------------------------------------
module fmhp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            data_byte,
   input  logic                  file_start,
   input  logic                  last_byte,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [2:0]            rsp_kind,
   output fmhp_pkg::cmd_type     cmd,
   input  fmhp_pkg::status_type  status
);
   fmhp_pkg::state_type st_ff, st_in;
   fmhp_pkg::phase_type ph_ff, ph_in;
   logic [3:0]  hi_ff, hi_in;
   logic [27:0] tag_ff, tag_in;
   logic [23:0] bcnt_ff, bcnt_in;
   logic [23:0] blen_ff, blen_in;
   logic [6:0]  btype_ff, btype_in;
   logic        fin_ff, fin_in;
   logic        seen_ff, seen_in;
   logic [4:0]  epos_ff, epos_in;
   logic        cf_ff, cf_in;
   logic        ci_ff, ci_in;
   logic [2:0]  k0_ff, k0_in, k1_ff, k1_in;
   logic        two_ff, two_in;
   logic        sel_ff, sel_in;

   always_comb begin
      logic [3:0] i;
      logic [2:0] ek0, ek1;
      logic [1:0] en;
      logic       do_end;
      st_in = st_ff; ph_in = ph_ff; hi_in = hi_ff; tag_in = tag_ff;
      bcnt_in = bcnt_ff; blen_in = blen_ff; btype_in = btype_ff;
      fin_in = fin_ff; seen_in = seen_ff; epos_in = epos_ff;
      cf_in = cf_ff; ci_in = ci_ff; k0_in = k0_ff; k1_in = k1_ff;
      two_in = two_ff; sel_in = sel_ff;
      cmd = '0;
      cmd.out_kind = sel_ff ? k1_ff : k0_ff;
      ek0 = fmhp_pkg::KIND_SUMMARY;
      ek1 = fmhp_pkg::KIND_SUMMARY;
      en = 2'd0;
      do_end = 1'b0;
      i = hi_ff;

      unique case (st_ff)
         fmhp_pkg::S_IN: begin
            if (req_tvalid) begin
               if (file_start) begin
                  cmd.clear = 1'b1;
                  ph_in = fmhp_pkg::PH_SIG; hi_in = '0; tag_in = '0;
                  bcnt_in = '0; blen_in = '0; btype_in = '0; fin_in = 1'b0;
                  seen_in = 1'b0; epos_in = '0; cf_in = 1'b1; ci_in = 1'b1;
               end
               i = hi_in;
               unique case (ph_in)
                  fmhp_pkg::PH_SIG: begin
                     if (i < 4'd4) cf_in = cf_in && (data_byte == fmhp_pkg::flac_sig_byte(i[1:0]));
                     else cf_in = 1'b0;
                     if (i < 4'd3) ci_in = ci_in && (data_byte == fmhp_pkg::id3_sig_byte(i[1:0]));
                     if (i == 4'd3 && cf_in) begin
                        cmd.mt_set = 1'b1; cmd.mt_val = 32'd4;
                        ph_in = fmhp_pkg::PH_HEAD; hi_in = '0;
                     end else if (i == 4'd2 && ci_in) begin
                        ph_in = fmhp_pkg::PH_ID3; hi_in = 4'd3;
                     end else if (!cf_in && !ci_in) begin
                        ek0 = fmhp_pkg::KIND_NO_SIG; en = 2'd1;
                        ph_in = fmhp_pkg::PH_DONE;
                     end else begin
                        hi_in = i + 4'd1;
                     end
                  end
                  fmhp_pkg::PH_ID3: begin
                     if (i >= 4'd6) tag_in = {tag_in[20:0], data_byte[6:0]};
                     if (i >= 4'd9) begin
                        cmd.mt_set = 1'b1; cmd.mt_val = 32'd10 + {4'd0, tag_in};
                        hi_in = '0;
                        ph_in = (tag_in != '0) ? fmhp_pkg::PH_SKIP : fmhp_pkg::PH_SIG2;
                     end else begin
                        hi_in = i + 4'd1;
                     end
                  end
                  fmhp_pkg::PH_SKIP: begin
                     tag_in = tag_in - 28'd1;
                     if (tag_in == '0) begin
                        ph_in = fmhp_pkg::PH_SIG2; hi_in = '0;
                     end
                  end
                  fmhp_pkg::PH_SIG2: begin
                     if (i > 4'd3 || data_byte != fmhp_pkg::flac_sig_byte(i[1:0])) begin
                        ek0 = fmhp_pkg::KIND_NO_SIG; en = 2'd1;
                        ph_in = fmhp_pkg::PH_DONE;
                     end else if (i == 4'd3) begin
                        cmd.mt_add = 1'b1; cmd.mt_val = 32'd4;
                        ph_in = fmhp_pkg::PH_HEAD; hi_in = '0;
                     end else begin
                        hi_in = i + 4'd1;
                     end
                  end
                  fmhp_pkg::PH_HEAD: begin
                     if (i == 4'd0) begin
                        fin_in = data_byte[7]; btype_in = data_byte[6:0]; blen_in = '0;
                     end else begin
                        blen_in = {blen_in[15:0], data_byte};
                     end
                     if (i >= 4'd3) begin
                        cmd.mt_add = 1'b1; cmd.mt_val = {8'd0, blen_in} + 32'd4;
                        bcnt_in = '0; epos_in = '0;
                        if (btype_in == fmhp_pkg::BT_STREAMINFO) cmd.si_clr = 1'b1;
                        if (blen_in == '0) do_end = 1'b1;
                        else ph_in = fmhp_pkg::PH_BODY;
                     end else begin
                        hi_in = i + 4'd1;
                     end
                  end
                  fmhp_pkg::PH_BODY: begin
                     if (btype_in == fmhp_pkg::BT_STREAMINFO) begin
                        if (bcnt_in < 24'd18) begin
                           cmd.si_wr = 1'b1; cmd.si_idx = bcnt_in[4:0];
                        end
                     end else if (btype_in == fmhp_pkg::BT_SEEKTABLE) begin
                        cmd.seek_shift = 1'b1;
                        if (epos_in == 5'd17) begin
                           epos_in = '0; cmd.seek_done = 1'b1;
                           if (status.seek_ok) begin
                              ek0 = fmhp_pkg::KIND_SEEK; en = 2'd1;
                           end
                        end else begin
                           epos_in = epos_in + 5'd1;
                        end
                     end
                     bcnt_in = bcnt_in + 24'd1;
                     if (bcnt_in == blen_in) do_end = 1'b1;
                  end
                  default: ph_in = fmhp_pkg::PH_DONE;
               endcase

               if (do_end) begin
                  if (btype_in == fmhp_pkg::BT_STREAMINFO && status.maxb_over) begin
                     if (en == 2'd0) ek0 = fmhp_pkg::KIND_TOO_LARGE;
                     else ek1 = fmhp_pkg::KIND_TOO_LARGE;
                     en = en + 2'd1;
                     ph_in = fmhp_pkg::PH_DONE;
                  end else begin
                     if (btype_in == fmhp_pkg::BT_STREAMINFO) seen_in = 1'b1;
                     if (fin_in) begin
                        if (en == 2'd0)
                           ek0 = seen_in ? fmhp_pkg::KIND_SUMMARY : fmhp_pkg::KIND_NO_SINFO;
                        else
                           ek1 = seen_in ? fmhp_pkg::KIND_SUMMARY : fmhp_pkg::KIND_NO_SINFO;
                        en = en + 2'd1;
                        ph_in = fmhp_pkg::PH_DONE;
                     end else begin
                        ph_in = fmhp_pkg::PH_HEAD; hi_in = '0;
                     end
                  end
               end

               if (last_byte && ph_in != fmhp_pkg::PH_DONE) begin
                  if (en == 2'd0) ek0 = fmhp_pkg::KIND_TRUNC;
                  else ek1 = fmhp_pkg::KIND_TRUNC;
                  en = en + 2'd1;
                  ph_in = fmhp_pkg::PH_DONE;
               end

               k0_in = ek0; k1_in = ek1; two_in = en[1]; sel_in = 1'b0;
               if (en != 2'd0) begin
                  if (ek0 == fmhp_pkg::KIND_SUMMARY || (en[1] && ek1 == fmhp_pkg::KIND_SUMMARY))
                     st_in = fmhp_pkg::S_MUL;
                  else
                     st_in = fmhp_pkg::S_OUT;
               end
            end
         end
         fmhp_pkg::S_MUL: begin
            cmd.mul_load = 1'b1;
            st_in = fmhp_pkg::S_DST;
         end
         fmhp_pkg::S_DST: begin
            cmd.div_start = 1'b1;
            st_in = fmhp_pkg::S_DIV;
         end
         fmhp_pkg::S_DIV: begin
            if (!status.div_busy) st_in = fmhp_pkg::S_OUT;
         end
         fmhp_pkg::S_OUT: begin
            if (rsp_tready) begin
               if (!sel_ff && two_ff) sel_in = 1'b1;
               else st_in = fmhp_pkg::S_IN;
            end
         end
         default: st_in = fmhp_pkg::S_IN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= fmhp_pkg::S_IN; ph_ff <= fmhp_pkg::PH_SIG; hi_ff <= '0;
         tag_ff <= '0; bcnt_ff <= '0; blen_ff <= '0; btype_ff <= '0;
         fin_ff <= 1'b0; seen_ff <= 1'b0; epos_ff <= '0;
         cf_ff <= 1'b1; ci_ff <= 1'b1; two_ff <= 1'b0; sel_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ph_ff <= ph_in; hi_ff <= hi_in;
         tag_ff <= tag_in; bcnt_ff <= bcnt_in; blen_ff <= blen_in; btype_ff <= btype_in;
         fin_ff <= fin_in; seen_ff <= seen_in; epos_ff <= epos_in;
         cf_ff <= cf_in; ci_ff <= ci_in; two_ff <= two_in; sel_ff <= sel_in;
      end
      k0_ff <= k0_in;
      k1_ff <= k1_in;
   end

   assign req_tready = (st_ff == fmhp_pkg::S_IN);
   assign rsp_tvalid = (st_ff == fmhp_pkg::S_OUT);
   assign rsp_kind   = sel_ff ? k1_ff : k0_ff;
endmodule

/* rtl/fmhp_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmhp_dp: parser datapath
// Holds the STREAMINFO bytes, the seek entry, the totals, the settings and
// the track length arithmetic, and forms the result word.
// ----------------------------------------------------------------------------
module fmhp_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [7:0]                         data_byte,
   input  logic                               csr_we,
   input  logic                               csr_addr,
   input  logic [15:0]                        csr_wdata,
   input  fmhp_pkg::cmd_type                  cmd,
   output fmhp_pkg::status_type               status,
   output logic [fmhp_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   logic [7:0]  si_ff [fmhp_pkg::SI_BYTES];
   logic [7:0]  si_in [fmhp_pkg::SI_BYTES];
   logic [7:0]  se_ff [fmhp_pkg::SI_BYTES];
   logic [7:0]  se_in [fmhp_pkg::SI_BYTES];
   logic [15:0] limit_ff, limit_in, cap_ff, cap_in, kept_ff, kept_in;
   logic [31:0] mt_ff, mt_in;
   logic [fmhp_pkg::DIVIDEND_W-1:0] prod_ff, prod_in, quot;
   logic        div_busy;

   logic [31:0] s_hi, s_lo, o_hi, o_lo, total, ms;
   logic [19:0] rate;
   logic [15:0] e_bs;

   always_comb begin
      for (int k = 0; k < fmhp_pkg::SI_BYTES; k++) begin
         si_in[k] = cmd.si_clr ? 8'd0 : si_ff[k];
         se_in[k] = se_ff[k];
      end
      if (cmd.si_wr) si_in[cmd.si_idx] = data_byte;
      if (cmd.seek_shift) begin
         for (int k = 0; k < fmhp_pkg::SI_BYTES - 1; k++) se_in[k] = se_ff[k+1];
         se_in[fmhp_pkg::SI_BYTES-1] = data_byte;
      end
   end

   assign s_hi = {se_in[0], se_in[1], se_in[2], se_in[3]};
   assign s_lo = {se_in[4], se_in[5], se_in[6], se_in[7]};
   assign o_hi = {se_in[8], se_in[9], se_in[10], se_in[11]};

   assign status.maxb_over = {si_in[2], si_in[3]} > limit_ff;
   assign status.seek_ok   = (s_hi == '0) && (s_lo != fmhp_pkg::ALL_ONES_32) &&
                             (o_hi == '0) && (kept_ff < cap_ff);
   assign status.div_busy  = div_busy;

   always_comb begin
      limit_in = limit_ff;
      cap_in   = cap_ff;
      if (csr_we) begin
         unique case (csr_addr)
            fmhp_pkg::CSR_MAX_BLOCK: limit_in = csr_wdata;
            fmhp_pkg::CSR_SEEK_CAP:  cap_in   = csr_wdata;
            default: ;
         endcase
      end
      kept_in = kept_ff;
      if (cmd.clear) kept_in = '0;
      if (cmd.seek_done && status.seek_ok) kept_in = kept_in + 16'd1;
      mt_in = mt_ff;
      if (cmd.mt_set) mt_in = cmd.mt_val;
      else if (cmd.mt_add) mt_in = mt_ff + cmd.mt_val;
      prod_in = prod_ff;
      if (cmd.mul_load) prod_in = fmhp_pkg::DIVIDEND_W'(total) * fmhp_pkg::DIVIDEND_W'(fmhp_pkg::MS_PER_SEC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= fmhp_pkg::MAX_BLOCK_RESET;
         cap_ff   <= fmhp_pkg::SEEK_CAP_RESET;
         kept_ff  <= '0;
      end else begin
         limit_ff <= limit_in;
         cap_ff   <= cap_in;
         kept_ff  <= kept_in;
      end
      mt_ff   <= mt_in;
      prod_ff <= prod_in;
      si_ff   <= si_in;
      se_ff   <= se_in;
   end

   fmhp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (rate),
      .busy     (div_busy),
      .quotient (quot)
   );

   assign rate  = {si_ff[10], si_ff[11], si_ff[12][7:4]};
   assign total = {si_ff[14], si_ff[15], si_ff[16], si_ff[17]};
   assign o_lo  = {se_ff[12], se_ff[13], se_ff[14], se_ff[15]};
   assign e_bs  = {se_ff[16], se_ff[17]};

   always_comb begin
      if (rate == '0) ms = '0;
      else if (quot[fmhp_pkg::DIVIDEND_W-1:32] != '0) ms = fmhp_pkg::ALL_ONES_32;
      else ms = quot[31:0];
   end

   // Layout from bit 0: sample_number, byte_offset, block_size, min_block,
   // min_frame, max_frame, sample_rate, channels, bits_per_sample,
   // length_ms, seek_count, two zero bits.
   always_comb begin
      rsp_tdata = '0;
      case (cmd.out_kind)
         fmhp_pkg::KIND_SUMMARY: begin
            rsp_tdata = {2'b00, kept_ff, ms,
                         6'({1'b0, si_ff[12][0], si_ff[13][7:4]}) + 6'd1,
                         4'({1'b0, si_ff[12][3:1]}) + 4'd1,
                         rate,
                         si_ff[7], si_ff[8], si_ff[9],
                         si_ff[4], si_ff[5], si_ff[6],
                         si_ff[0], si_ff[1],
                         si_ff[2], si_ff[3],
                         mt_ff, total};
         end
         fmhp_pkg::KIND_SEEK: begin
            rsp_tdata[31:0]  = {se_ff[4], se_ff[5], se_ff[6], se_ff[7]};
            rsp_tdata[63:32] = o_lo;
            rsp_tdata[79:64] = e_bs;
         end
         default: rsp_tdata = '0;
      endcase
   end
endmodule

/* rtl/flac_metadata_header_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flac_metadata_header_parser_unit: FLAC metadata header parser
// Byte stream in, seek point, summary and error words out.
// ----------------------------------------------------------------------------
//  channel | ports      | carries
//  --------+------------+-----------------------------------------------
//  request | req_*      | one file byte per word, file start, last byte
//  result  | rsp_*      | kind plus summary or seek point fields
//  setup   | csr_*      | block size limit and seek point capacity
//
// The controller accepts a new word only in its input state, not while a
// result waits or is being computed. A byte that yields results holds off
// input until they have all been taken. A byte that ends the last block
// with a summary first passes through the multiply, the divider start and
// the one-bit-per-cycle length divider before the summary is shown.
// Reset is synchronous and active high and restores the register defaults.
// ----------------------------------------------------------------------------
module flac_metadata_header_parser_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // data_byte
   input  logic                            req_tuser,   // file_start
   input  logic                            req_tlast,   // last_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // sample_number, byte_offset, block_size, min_block, min_frame,
   // max_frame, sample_rate, channels, bits_per_sample, length_ms,
   // seek_count, zero pad
   output logic [fmhp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]                      rsp_tuser,   // kind
   input  logic                            csr_we,
   input  logic                            csr_addr,
   input  logic [15:0]                     csr_wdata
);
   fmhp_pkg::cmd_type    cmd;
   fmhp_pkg::status_type status;

   // The controller owns all parse sequencing; the datapath stores bytes,
   // keeps the totals and settings, evaluates checks and forms the result.
   fmhp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .data_byte  (req_tdata),
      .file_start (req_tuser),
      .last_byte  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

   fmhp_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .data_byte (req_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );
endmodule

/* rtl/fmhp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmhp_checker: port level checks for the parser
// Watches the top level ports and is bound to every instance.
// ----------------------------------------------------------------------------
module fmhp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [fmhp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [2:0]                      rsp_tuser
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result waits");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= fmhp_pkg::KIND_TRUNC)
      else $error("unknown result kind");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != fmhp_pkg::KIND_SUMMARY && rsp_tuser != fmhp_pkg::KIND_SEEK
      |-> rsp_tdata == '0)
      else $error("error word carries data");

   a_rst: assert property (@(posedge clock) $fell(reset) |-> req_tready && !rsp_tvalid)
      else $error("not idle after reset");
endmodule

bind flac_metadata_header_parser_unit fmhp_checker u_fmhp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
